// File: hdl/priority_ready_queue_scheduler_assert.svh
// Assertion macros used by the scheduler datapath.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define PRQS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PRQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/prqs_pkg.sv
// Package with shared types, constants and helpers for the ready-queue scheduler.
package prqs_pkg;

    localparam int THREAD_SLOTS    = 8;
    localparam int PRIORITY_LEVELS = 16;
    localparam int SLOT_W          = $clog2(THREAD_SLOTS);
    localparam int LEVEL_W         = $clog2(PRIORITY_LEVELS);

    localparam int KIND_W     = 4;
    localparam int PRIO_W     = 5;
    localparam int TARGET_W   = 3;
    localparam int RET_W      = 5;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 1;

    typedef logic [SLOT_W:0] link_t;
    localparam link_t LINK_NIL = {1'b1, {SLOT_W{1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE     = 4'd0,
        KIND_EXIT       = 4'd1,
        KIND_WAIT       = 4'd2,
        KIND_SLEEP      = 4'd3,
        KIND_WAKEUP     = 4'd4,
        KIND_GETID      = 4'd5,
        KIND_CHANGE     = 4'd6,
        KIND_FAULT      = 4'd7,
        KIND_RESCHEDULE = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ENQ_CALLER,
        ENQ_NEW,
        ENQ_TARGET
    } enq_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_APPLY,
        ST_REQUEUE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic     load;
        logic     deq;
        logic     enq;
        enq_sel_t enq_sel;
        logic     clear;
        logic     alloc;
        logic     set_prio;
        logic     capture_ret;
        logic     scan;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  have;
        logic  halted;
        logic  create_ok;
        logic  alloc_done;
        logic  target_ok;
        logic  out_busy;
    } status_t;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [PRIO_W-2:0] p);
        logic [LEVEL_W-1:0] lvl;
        if (int'(p) >= PRIORITY_LEVELS)
            lvl = LEVEL_W'(PRIORITY_LEVELS - 1);
        else
            lvl = LEVEL_W'(p);
        return lvl;
    endfunction

endpackage

// File: hdl/priority_ready_queue_scheduler.sv
// Top level of the fixed-priority FIFO ready-queue scheduler.
// Each event is registered in an accept step, then goes through dequeue of the
// running thread, the event's queue rule, the requeue of the caller, new or
// woken thread, and the priority scan, each one step of the sequencer over the
// slot and level tables; once the system is halted, the sequencer goes from the
// dequeue step straight to the scan. The result is loaded into an output
// register at the scan step; if it is not yet taken when the next event reaches
// its scan step, that event holds there. A new event is taken only while the
// sequencer is idle, so a new event is not taken before the last one is through.
module priority_ready_queue_scheduler
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [prqs_pkg::IN_DATA_W-1:0]       s_tdata,  // priority_value, target_thread
    input  logic [prqs_pkg::KIND_W-1:0]          s_tuser,  // kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [prqs_pkg::OUT_DATA_W-1:0]      m_tdata,  // return_value, running_thread, system_halted
    output logic [prqs_pkg::OUT_USER_W-1:0]      m_tuser   // has_return
);

    prqs_pkg::cmd_t    cmd;
    prqs_pkg::status_t status;

    prqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prqs_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// File: hdl/prqs_ctrl.sv
// Sequencer that steps each event through dequeue, apply, requeue and scan (apply and requeue are skipped once halted).
module prqs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  prqs_pkg::status_t status,
    output prqs_pkg::cmd_t   cmd
);

    prqs_pkg::state_t state_reg;
    prqs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prqs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.enq_sel = prqs_pkg::ENQ_CALLER;
        s_tready    = 1'b0;
        case (state_reg)
            prqs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                    state_next = prqs_pkg::ST_DEQ;
            end
            prqs_pkg::ST_DEQ:
            begin
                if (status.halted)
                begin
                    state_next = prqs_pkg::ST_SCAN;
                end
                else
                begin
                    cmd.deq    = status.have && (status.kind <= prqs_pkg::KIND_FAULT);
                    state_next = prqs_pkg::ST_APPLY;
                end
            end
            prqs_pkg::ST_APPLY:
            begin
                cmd.capture_ret = 1'b1;
                case (status.kind)
                    prqs_pkg::KIND_CREATE:
                    begin
                        cmd.enq   = status.have;
                        cmd.alloc = status.create_ok;
                    end
                    prqs_pkg::KIND_WAIT,
                    prqs_pkg::KIND_GETID,
                    prqs_pkg::KIND_WAKEUP:
                    begin
                        cmd.enq = status.have;
                    end
                    prqs_pkg::KIND_EXIT,
                    prqs_pkg::KIND_FAULT:
                    begin
                        cmd.clear = status.have;
                    end
                    prqs_pkg::KIND_CHANGE:
                    begin
                        cmd.set_prio = status.have;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = prqs_pkg::ST_REQUEUE;
            end
            prqs_pkg::ST_REQUEUE:
            begin
                case (status.kind)
                    prqs_pkg::KIND_CREATE:
                    begin
                        cmd.enq     = status.alloc_done;
                        cmd.enq_sel = prqs_pkg::ENQ_NEW;
                    end
                    prqs_pkg::KIND_CHANGE:
                    begin
                        cmd.enq     = status.have;
                        cmd.enq_sel = prqs_pkg::ENQ_CALLER;
                    end
                    prqs_pkg::KIND_WAKEUP:
                    begin
                        cmd.enq     = status.target_ok;
                        cmd.enq_sel = prqs_pkg::ENQ_TARGET;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = prqs_pkg::ST_SCAN;
            end
            prqs_pkg::ST_SCAN:
            begin
                if (!status.out_busy)
                begin
                    cmd.scan   = 1'b1;
                    state_next = prqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prqs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/prqs_datapath.sv
// Slot table, level queues, running slot, halt flag and result register.
`include "priority_ready_queue_scheduler_assert.svh"

module prqs_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [prqs_pkg::IN_DATA_W-1:0]         s_tdata,
    input  logic [prqs_pkg::KIND_W-1:0]            s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [prqs_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [prqs_pkg::OUT_USER_W-1:0]        m_tuser,
    input  prqs_pkg::cmd_t                         cmd,
    output prqs_pkg::status_t                      status
);

    localparam int SW = prqs_pkg::SLOT_W;
    localparam int LW = prqs_pkg::LEVEL_W;
    localparam int NS = prqs_pkg::THREAD_SLOTS;
    localparam int NL = prqs_pkg::PRIORITY_LEVELS;

    logic [prqs_pkg::KIND_W-1:0]   kind_reg;
    logic [prqs_pkg::PRIO_W-1:0]   prio_value_reg;
    logic [prqs_pkg::TARGET_W-1:0] target_reg;
    prqs_pkg::link_t               caller_reg;
    logic                          have_reg;
    logic [SW-1:0]                 alloc_reg;
    logic                          alloc_done_reg;

    logic [NS-1:0]                 used_reg;
    logic [NS-1:0]                 ready_reg;
    logic [LW-1:0]                 prio_reg [NS];
    prqs_pkg::link_t               link_reg [NS];
    prqs_pkg::link_t               head_reg [NL];
    prqs_pkg::link_t               tail_reg [NL];
    prqs_pkg::link_t               running_reg;
    logic                          halted_reg;

    logic [prqs_pkg::RET_W-1:0]    ret_reg;
    logic                          has_ret_reg;
    logic                          out_valid_reg;
    logic [prqs_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                          out_user_reg;

    logic                          have_now;
    logic [SW-1:0]                 caller_idx;
    prqs_pkg::link_t               enq_link;
    logic [SW-1:0]                 enq_idx;
    logic                          enq_go;
    logic [SW-1:0]                 slot_sel;
    logic [LW-1:0]                 prio_rd;
    prqs_pkg::link_t               link_rd;
    prqs_pkg::link_t               head_rd;
    prqs_pkg::link_t               tail_rd;
    logic                          deq_hit;
    logic [NL-1:0]                 nonempty;
    logic                          scan_any;
    logic [LW-1:0]                 scan_level;
    logic                          free_found;
    logic [SW-1:0]                 free_idx;
    logic                          create_ok;
    logic [SW-1:0]                 target_idx;
    logic                          target_ok;
    logic [LW-1:0]                 new_prio;
    logic [prqs_pkg::RET_W-1:0]    ret_next;
    logic                          has_ret_next;
    prqs_pkg::link_t               running_out;
    logic                          halted_out;
    logic [prqs_pkg::OUT_DATA_W-1:0] out_data_next;

    assign caller_idx = caller_reg[SW-1:0];
    assign have_now   = !running_reg[SW] && (int'(running_reg[SW-1:0]) < NS)
                        && used_reg[running_reg[SW-1:0]];

    always_comb
    begin
        case (cmd.enq_sel)
            prqs_pkg::ENQ_NEW:    enq_link = {1'b0, alloc_reg};
            prqs_pkg::ENQ_TARGET: enq_link = {1'b0, target_idx};
            default:              enq_link = caller_reg;
        endcase
    end

    assign enq_idx  = enq_link[SW-1:0];
    assign slot_sel = cmd.enq ? enq_idx : caller_idx;
    assign prio_rd  = prio_reg[slot_sel];
    assign link_rd  = link_reg[caller_idx];
    assign head_rd  = head_reg[cmd.scan ? scan_level : prio_rd];
    assign tail_rd  = tail_reg[prio_rd];
    assign enq_go   = cmd.enq && !ready_reg[enq_idx];
    assign deq_hit  = ready_reg[caller_idx] && (head_rd == caller_reg);
    assign new_prio = prqs_pkg::clamp_level(prio_value_reg[prqs_pkg::PRIO_W-2:0]);

    always_comb
    begin
        scan_level = '0;
        for (int i = NL - 1; i >= 0; i--)
        begin
            nonempty[i] = !head_reg[i][SW];
            if (nonempty[i])
                scan_level = LW'(i);
        end
        scan_any = |nonempty;
    end

    always_comb
    begin
        free_idx = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
                free_idx = SW'(i);
        end
        free_found = !(&used_reg);
    end

    assign create_ok  = !prio_value_reg[prqs_pkg::PRIO_W-1] && free_found;
    assign target_idx = SW'(target_reg);
    assign target_ok  = (int'(target_reg) < NS) && used_reg[target_idx];

    always_comb
    begin
        ret_next     = '0;
        has_ret_next = 1'b0;
        case (prqs_pkg::kind_t'(kind_reg))
            prqs_pkg::KIND_CREATE:
            begin
                has_ret_next = 1'b1;
                ret_next     = create_ok ? prqs_pkg::RET_W'(free_idx) : '1;
            end
            prqs_pkg::KIND_WAIT,
            prqs_pkg::KIND_SLEEP:
            begin
                has_ret_next = have_reg;
            end
            prqs_pkg::KIND_WAKEUP:
            begin
                has_ret_next = 1'b1;
            end
            prqs_pkg::KIND_GETID:
            begin
                has_ret_next = have_reg;
                ret_next     = have_reg ? prqs_pkg::RET_W'(caller_idx) : '0;
            end
            prqs_pkg::KIND_CHANGE:
            begin
                has_ret_next = have_reg;
                ret_next     = have_reg ? prqs_pkg::RET_W'(prio_rd) : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        running_out = running_reg;
        halted_out  = halted_reg;
        if (!halted_reg)
        begin
            if (scan_any)
                running_out = head_rd;
            else
                halted_out = 1'b1;
        end
        out_data_next = '0;
        out_data_next[prqs_pkg::RET_W-1:0] = ret_reg;
        out_data_next[prqs_pkg::RET_W +: prqs_pkg::TARGET_W] =
            running_out[SW] ? '0 : prqs_pkg::TARGET_W'(running_out[SW-1:0]);
        out_data_next[prqs_pkg::RET_W + prqs_pkg::TARGET_W] = halted_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            ready_reg      <= '0;
            for (int i = 0; i < NS; i++)
            begin
                prio_reg[i] <= '0;
                link_reg[i] <= prqs_pkg::LINK_NIL;
            end
            for (int i = 0; i < NL; i++)
            begin
                head_reg[i] <= prqs_pkg::LINK_NIL;
                tail_reg[i] <= prqs_pkg::LINK_NIL;
            end
            running_reg    <= prqs_pkg::LINK_NIL;
            halted_reg     <= 1'b0;
            alloc_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.deq && deq_hit)
            begin
                head_reg[prio_rd] <= link_rd;
                if (link_rd[SW])
                    tail_reg[prio_rd] <= prqs_pkg::LINK_NIL;
                ready_reg[caller_idx] <= 1'b0;
                link_reg[caller_idx]  <= prqs_pkg::LINK_NIL;
            end

            if (enq_go)
            begin
                link_reg[enq_idx] <= prqs_pkg::LINK_NIL;
                if (tail_rd[SW])
                    head_reg[prio_rd] <= enq_link;
                else
                    link_reg[tail_rd[SW-1:0]] <= enq_link;
                tail_reg[prio_rd]  <= enq_link;
                ready_reg[enq_idx] <= 1'b1;
            end

            if (cmd.enq && (cmd.enq_sel == prqs_pkg::ENQ_TARGET))
                running_reg <= enq_link;

            if (cmd.clear)
            begin
                used_reg[caller_idx]  <= 1'b0;
                ready_reg[caller_idx] <= 1'b0;
                prio_reg[caller_idx]  <= '0;
                link_reg[caller_idx]  <= prqs_pkg::LINK_NIL;
            end

            if (cmd.set_prio && !prio_value_reg[prqs_pkg::PRIO_W-1])
                prio_reg[caller_idx] <= new_prio;

            if (cmd.alloc)
            begin
                used_reg[free_idx]  <= 1'b1;
                ready_reg[free_idx] <= 1'b0;
                prio_reg[free_idx]  <= new_prio;
                link_reg[free_idx]  <= prqs_pkg::LINK_NIL;
                running_reg         <= {1'b0, free_idx};
            end

            if (cmd.load)
                alloc_done_reg <= 1'b0;
            else if (cmd.alloc)
                alloc_done_reg <= 1'b1;

            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            if (cmd.scan)
            begin
                running_reg   <= running_out;
                halted_reg    <= halted_out;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg       <= s_tuser;
            prio_value_reg <= s_tdata[prqs_pkg::PRIO_W-1:0];
            target_reg     <= s_tdata[prqs_pkg::PRIO_W +: prqs_pkg::TARGET_W];
            caller_reg     <= running_reg;
            have_reg       <= have_now;
            ret_reg        <= '0;
            has_ret_reg    <= 1'b0;
        end
        else if (cmd.capture_ret)
        begin
            ret_reg     <= ret_next;
            has_ret_reg <= has_ret_next;
        end
        if (cmd.alloc)
            alloc_reg <= free_idx;
        if (cmd.scan)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= has_ret_reg;
        end
    end

    assign status.kind       = prqs_pkg::kind_t'(kind_reg);
    assign status.have       = have_reg;
    assign status.halted     = halted_reg;
    assign status.create_ok  = create_ok;
    assign status.alloc_done = alloc_done_reg;
    assign status.target_ok  = target_ok;
    assign status.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `PRQS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg, "halt flag cleared")
    `PRQS_ASSERT_IMPLIES(a_scan_slot_free, clk, rst_n, cmd.scan, !(out_valid_reg && !m_tready), "result overwritten before transfer")
    `PRQS_ASSERT_NEXT(a_scan_gives_result, clk, rst_n, cmd.scan, out_valid_reg, "scan without result")
    `PRQS_ASSERT_NEXT(a_halted_keeps_running, clk, rst_n, halted_reg && cmd.scan, $stable(running_reg), "running slot moved while halted")

endmodule
